[design/rgb_hsl_byte_converter_unit_macros.svh]
// ----------------------------------------------------------------------------
// rgb/hsl converter assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef RGB_HSL_BYTE_CONVERTER_UNIT_MACROS_SVH
`define RGB_HSL_BYTE_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication
`define RHB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RHB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rhb_pkg.sv]
// ----------------------------------------------------------------------------
// rhb_pkg
// types and constants of the rgb/hsl byte converter pipeline
// ----------------------------------------------------------------------------
package rhb_pkg;

  localparam int unsigned DivSteps = 8;
  localparam int unsigned DivStages = 4;
  localparam int unsigned StepsPerStage = DivSteps / DivStages;

  // how one hsl channel is formed
  typedef enum logic [1:0] {
    KIND_RAMP,
    KIND_HIGH,
    KIND_LOW
  } kind_e;

  // first stage: channel extremes, hue difference, m2 and wrapped hues
  typedef struct packed {
    logic              act;
    logic              grey;
    logic              szero;
    logic [7:0]        third;
    logic [7:0]        delta;
    logic [8:0]        sum;
    logic signed [11:0] d;
    logic [16:0]       m2;
    logic [7:0]        lum;
    logic [2:0][7:0]   hue;
  } a_t;

  // second stage: scaled hue numerator, saturation base, interpolation products
  typedef struct packed {
    logic              act;
    logic              force_z;
    logic [7:0]        third;
    logic [7:0]        delta;
    logic signed [19:0] num85;
    logic [8:0]        den2;
    logic [8:0]        sd;
    logic [16:0]       m1;
    logic [16:0]       m2;
    logic [2:0][1:0]   kind;
    logic [2:0][24:0]  prod;
  } b_t;

  // divider stages: three lanes of partial remainder, divisor and quotient
  typedef struct packed {
    logic              act;
    logic              force_z;
    logic [7:0]        third;
    logic [2:0][25:0]  rem;
    logic [2:0][16:0]  dvs;
    logic [2:0][7:0]   quo;
  } div_t;

endpackage

[design/rgb_hsl_byte_converter_unit.sv]
// ----------------------------------------------------------------------------
// rgb_hsl_byte_converter_unit
// pipelined 8-bit rgb to byte-scaled hsl and back converter
// ----------------------------------------------------------------------------
// a request is registered in stages a, b and c and in each divider stage before its result reaches the output
// throughput: one pixel per cycle while the output is not stalled, set by the 3-lane divider split 2 bits a stage
// stalls back up stage by stage; bubbles are filled while the output waits
// reset clears all valid bits asynchronously; data registers are not reset
// ----------------------------------------------------------------------------
`include "rgb_hsl_byte_converter_unit_macros.svh"

module rgb_hsl_byte_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // in_first[7:0], in_second[15:8], in_third[23:16]
  input  logic        s_axis_tuser_i,  // action[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // out_first[7:0], out_second[15:8], out_third[23:16]
);

  localparam int unsigned NDiv = rhb_pkg::DivStages;
  localparam int unsigned Spb  = rhb_pkg::StepsPerStage;

  rhb_pkg::a_t   a_d, a_q;
  rhb_pkg::b_t   b_d, b_q;
  rhb_pkg::div_t div_d [0:NDiv];
  rhb_pkg::div_t div_q [0:NDiv];
  logic          a_v_q, b_v_q;
  logic [NDiv:0] dv_q;
  logic [NDiv:0] en_div;
  logic          en_a, en_b;

  // stall chain: a stage loads when empty or when the next one loads
  always_comb begin
    en_div[NDiv] = !dv_q[NDiv] || m_axis_tready_i;
    for (int j = NDiv - 1; j >= 0; j--) begin
      en_div[j] = !dv_q[j] || en_div[j+1];
    end
    en_b = !b_v_q || en_div[0];
    en_a = !a_v_q || en_b;
  end

  assign s_axis_tready_o = en_a;

  // stage a: extremes and hue difference, or m2 and the three hue offsets
  always_comb begin
    logic [7:0] r, g, bl, mx, mn, dl;
    logic [8:0] sm;
    logic [9:0] sm1;
    r  = s_axis_tdata_i[7:0];
    g  = s_axis_tdata_i[15:8];
    bl = s_axis_tdata_i[23:16];
    if (r > g) begin
      mx = (r > bl) ? r : bl;
      mn = (g < bl) ? g : bl;
    end else begin
      mx = (g > bl) ? g : bl;
      mn = (r < bl) ? r : bl;
    end
    dl  = mx - mn;
    sm  = {1'b0, mx} + {1'b0, mn};
    sm1 = {1'b0, sm} + 10'd1;
    a_d.act   = s_axis_tuser_i;
    a_d.grey  = (mx == mn);
    a_d.szero = (g == 8'd0);
    a_d.delta = dl;
    a_d.sum   = sm;
    a_d.lum   = bl;
    a_d.third = s_axis_tuser_i ? bl : sm1[8:1];
    if (r == mx) begin
      a_d.d = $signed({4'b0, g}) - $signed({4'b0, bl});
    end else if (g == mx) begin
      a_d.d = $signed({3'b0, dl, 1'b0}) + $signed({4'b0, bl}) - $signed({4'b0, r});
    end else begin
      a_d.d = $signed({2'b0, dl, 2'b0}) + $signed({4'b0, r}) - $signed({4'b0, g});
    end
    // m2 over 65025, with hue in r, saturation in g, lightness in bl
    if (bl < 8'd128) begin
      a_d.m2 = 17'(bl) * (17'd255 + 17'(g));
    end else begin
      a_d.m2 = 17'(17'd255 * (17'(bl) + 17'(g)) - 17'(bl) * 17'(g));
    end
    a_d.hue[0] = (r > 8'd170) ? 8'(r - 8'd170) : 8'(r + 8'd85);
    a_d.hue[1] = r;
    a_d.hue[2] = (r < 8'd85) ? 8'(r + 8'd170) : 8'(r - 8'd85);
  end

  // stage b: hue numerator, saturation divisor, interpolation products
  always_comb begin
    logic [16:0] m1, diff;
    logic [7:0]  t;
    m1   = 17'(17'd510 * 17'(a_q.lum) - a_q.m2);
    diff = a_q.m2 - m1;
    b_d.act     = a_q.act;
    b_d.force_z = a_q.act ? a_q.szero : a_q.grey;
    b_d.third   = a_q.third;
    b_d.delta   = a_q.delta;
    b_d.num85   = 20'(a_q.d) * 20'sd85;
    b_d.den2    = {a_q.delta, 1'b0};
    b_d.sd      = (a_q.sum < 9'd256) ? a_q.sum : 9'(9'd511 - a_q.sum);
    b_d.m1      = m1;
    b_d.m2      = a_q.m2;
    for (int k = 0; k < 3; k++) begin
      t = 8'd0;
      if (a_q.hue[k] <= 8'd42) begin
        b_d.kind[k] = rhb_pkg::KIND_RAMP;
        t           = a_q.hue[k];
      end else if (a_q.hue[k] <= 8'd127) begin
        b_d.kind[k] = rhb_pkg::KIND_HIGH;
      end else if (a_q.hue[k] <= 8'd169) begin
        b_d.kind[k] = rhb_pkg::KIND_RAMP;
        t           = 8'(8'd170 - a_q.hue[k]);
      end else begin
        b_d.kind[k] = rhb_pkg::KIND_LOW;
      end
      b_d.prod[k] = 25'(8'(t * 8'd6)) * 25'(diff);
    end
  end

  // stage c: rounded dividends and divisors for the three divider lanes
  always_comb begin
    logic signed [19:0] n;
    n = (b_q.num85 < 0) ? b_q.num85 + 20'sd255 * $signed({11'b0, b_q.den2}) : b_q.num85;
    div_d[0].act     = b_q.act;
    div_d[0].force_z = b_q.force_z;
    div_d[0].third   = b_q.third;
    div_d[0].quo     = '0;
    if (!b_q.act) begin
      div_d[0].rem[0] = 26'({n[18:0], 1'b0}) + 26'(b_q.den2);
      div_d[0].dvs[0] = 17'({b_q.den2, 1'b0});
      div_d[0].rem[1] = 26'(18'd510 * 18'(b_q.delta)) + 26'(b_q.sd);
      div_d[0].dvs[1] = 17'({b_q.sd, 1'b0});
      div_d[0].rem[2] = '0;
      div_d[0].dvs[2] = 17'd1;
    end else begin
      for (int k = 0; k < 3; k++) begin
        case (rhb_pkg::kind_e'(b_q.kind[k]))
          rhb_pkg::KIND_RAMP: begin
            div_d[0].rem[k] = 26'({(25'(25'd255 * 25'(b_q.m1)) + b_q.prod[k]), 1'b0})
                              + 26'd65025;
            div_d[0].dvs[k] = 17'd130050;
          end
          rhb_pkg::KIND_HIGH: begin
            div_d[0].rem[k] = 26'({b_q.m2, 1'b0}) + 26'd255;
            div_d[0].dvs[k] = 17'd510;
          end
          default: begin
            div_d[0].rem[k] = 26'({b_q.m1, 1'b0}) + 26'd255;
            div_d[0].dvs[k] = 17'd510;
          end
        endcase
      end
    end
  end

  // divider stages: restoring division, two quotient bits per stage
  for (genvar j = 1; j <= NDiv; j++) begin : g_div
    always_comb begin
      logic [25:0] sh;
      int          bitn;
      div_d[j] = div_q[j-1];
      for (int k = 0; k < 3; k++) begin
        for (int s = 0; s < Spb; s++) begin
          bitn = rhb_pkg::DivSteps - 1 - (j - 1) * Spb - s;
          sh   = {9'b0, div_d[j].dvs[k]} << bitn;
          if (div_d[j].rem[k] >= sh) begin
            div_d[j].rem[k]       = div_d[j].rem[k] - sh;
            div_d[j].quo[k][bitn[2:0]] = 1'b1;
          end
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      dv_q  <= '0;
    end else begin
      if (en_a) begin
        a_v_q <= s_axis_tvalid_i;
      end
      if (en_b) begin
        b_v_q <= a_v_q;
      end
      if (en_div[0]) begin
        dv_q[0] <= b_v_q;
      end
      for (int j = 1; j <= NDiv; j++) begin
        if (en_div[j]) begin
          dv_q[j] <= dv_q[j-1];
        end
      end
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    if (en_a) begin
      a_q <= a_d;
    end
    if (en_b) begin
      b_q <= b_d;
    end
    for (int j = 0; j <= NDiv; j++) begin
      if (en_div[j]) begin
        div_q[j] <= div_d[j];
      end
    end
  end

  // result select: grey and zero-saturation cases override the quotients
  always_comb begin
    m_axis_tvalid_o = dv_q[NDiv];
    if (!div_q[NDiv].act) begin
      m_axis_tdata_o[7:0]   = div_q[NDiv].force_z ? 8'd0 : div_q[NDiv].quo[0];
      m_axis_tdata_o[15:8]  = div_q[NDiv].force_z ? 8'd0 : div_q[NDiv].quo[1];
      m_axis_tdata_o[23:16] = div_q[NDiv].third;
    end else if (div_q[NDiv].force_z) begin
      m_axis_tdata_o = {3{div_q[NDiv].third}};
    end else begin
      m_axis_tdata_o = {div_q[NDiv].quo[2], div_q[NDiv].quo[1], div_q[NDiv].quo[0]};
    end
  end

  `RHB_ASSERT_IMPL(a_full_when_blocked, !s_axis_tready_o, a_v_q && b_v_q && (&dv_q), "input blocked with a bubble in the pipe")
  `RHB_ASSERT_NEXT(a_accept_loads, s_axis_tvalid_i && s_axis_tready_o, a_v_q, "accepted request did not reach the first stage")
  `RHB_ASSERT_NEXT(a_last_holds, dv_q[NDiv] && !m_axis_tready_i, dv_q[NDiv] && $stable(div_q[NDiv]), "stalled result stage changed")

endmodule
